// ===== rtl/core/dlp_pkg.sv =====
// shared types and character constants of the decimal list parser
package dlp_pkg;

	typedef enum logic [1:0] {
		CMD_DIGIT = 2'd0,
		CMD_SEP   = 2'd1,
		CMD_EOT   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [3:0]  digit;
	} cmd_t;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

endpackage

// ===== rtl/core/dlp_fifo.sv =====
// small register queue used between the parser parts
module dlp_fifo #(
	parameter int WIDTH      = 8,
	parameter int DEPTH_LOG2 = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [WIDTH-1:0]      mem_q [DEPTH];
	logic [DEPTH_LOG2-1:0] wr_ptr_q;
	logic [DEPTH_LOG2-1:0] rd_ptr_q;
	logic [DEPTH_LOG2:0]   count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full    = (count_q == (DEPTH_LOG2+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/dlp_front.sv =====
// character classifier: turns one character into a parser command
module dlp_front (
	input  logic         [7:0] char_code,
	input  logic               end_of_text,
	output dlp_pkg::cmd_t      cmd,
	output logic               keep
);
	import dlp_pkg::*;

	logic [3:0] offset;

	assign offset = 4'(char_code - CH_ZERO);

	always_comb begin
		cmd.kind  = CMD_SEP;
		cmd.digit = offset;
		keep      = 1'b0;
		if (end_of_text) begin
			cmd.kind = CMD_EOT;
			keep     = 1'b1;
		end else if (char_code inside {[CH_TAB:CH_CR], CH_SPACE, CH_COMMA}) begin
			cmd.kind = CMD_SEP;
			keep     = 1'b1;
		end else if (char_code inside {[CH_ZERO:CH_NINE]}) begin
			cmd.kind = CMD_DIGIT;
			keep     = 1'b1;
		end
	end

endmodule

// ===== rtl/core/dlp_back.sv =====
// number builder: accumulates digits and emits list elements
module dlp_back #(
	parameter int NUMBER_WIDTH = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_avail,
	input  dlp_pkg::cmd_t           cmd,
	output logic                    cmd_pop,
	input  logic                    res_full,
	output logic                    res_push,
	output logic [NUMBER_WIDTH-1:0] res_number,
	output logic                    res_valid,
	output logic                    res_end
);
	import dlp_pkg::*;

	logic                    in_number_q;
	logic [NUMBER_WIDTH-1:0] acc_q;
	logic [NUMBER_WIDTH+3:0] acc_x;
	logic [NUMBER_WIDTH+3:0] grown;
	logic [NUMBER_WIDTH-1:0] grown_sat;
	logic                    go;

	assign go      = cmd_avail && !res_full;
	assign cmd_pop = go;

	// acc * 10 + digit, saturating
	assign acc_x     = {4'b0000, acc_q};
	assign grown     = (acc_x << 3) + (acc_x << 1) + {{NUMBER_WIDTH{1'b0}}, cmd.digit};
	assign grown_sat = (|grown[NUMBER_WIDTH+3:NUMBER_WIDTH]) ? {NUMBER_WIDTH{1'b1}}
	                                                         : grown[NUMBER_WIDTH-1:0];

	always_comb begin
		res_push   = 1'b0;
		res_number = acc_q;
		res_valid  = in_number_q;
		res_end    = 1'b0;
		case (cmd.kind)
			CMD_SEP: begin
				res_push = go && in_number_q;
			end
			CMD_EOT: begin
				res_push = go;
				res_end  = 1'b1;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_number_q <= 1'b0;
			acc_q       <= '0;
		end else if (go) begin
			case (cmd.kind)
				CMD_DIGIT: begin
					if (in_number_q) begin
						acc_q <= grown_sat;
					end else if (cmd.digit != 4'd0) begin
						acc_q       <= NUMBER_WIDTH'(cmd.digit);
						in_number_q <= 1'b1;
					end
				end
				CMD_SEP, CMD_EOT: begin
					acc_q       <= '0;
					in_number_q <= 1'b0;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	a_push_needs_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> cmd_pop)
		else $error("result pushed without a command");

	a_idle_acc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!in_number_q |-> (acc_q == '0))
		else $error("accumulator not clear outside a number");

	a_number_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_number_q |-> (acc_q != '0))
		else $error("number in progress holds zero");

	a_eot_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(go && cmd.kind == CMD_EOT) |=> !in_number_q)
		else $error("end of text did not reset the parser");

endmodule

// ===== rtl/core/decimal_list_parser_core.sv =====
// each command is registered in the command queue, each result in the result queue
// throughput: one character per cycle while full is low
// characters that neither build nor end a number are taken and dropped at the front
// a full result queue stalls the builder, and a full command queue raises full
// asynchronous active-low reset empties both queues and clears the pending number
module decimal_list_parser_core #(
	parameter int NUMBER_WIDTH = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [7:0]              char_code,
	input  logic                    end_of_text,
	output logic                    empty,
	input  logic                    pop,
	output logic [NUMBER_WIDTH-1:0] number,
	output logic                    number_valid,
	output logic                    list_end
);
	import dlp_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = NUMBER_WIDTH + 2;

	cmd_t                    front_cmd;
	logic                    front_keep;
	logic [CMD_W-1:0]        cmd_rd_data;
	cmd_t                    back_cmd;
	logic                    cmd_empty;
	logic                    cmd_pop;
	logic                    res_full;
	logic                    res_push;
	logic [NUMBER_WIDTH-1:0] res_number;
	logic                    res_valid;
	logic                    res_end;
	logic [RES_W-1:0]        res_rd_data;

	dlp_front u_front (
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.cmd         (front_cmd),
		.keep        (front_keep)
	);

	dlp_fifo #(
		.WIDTH      (CMD_W),
		.DEPTH_LOG2 (2)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && front_keep),
		.wr_data (front_cmd),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd_data),
		.full    (full),
		.empty   (cmd_empty)
	);

	assign back_cmd = cmd_t'(cmd_rd_data);

	dlp_back #(
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_avail  (!cmd_empty),
		.cmd        (back_cmd),
		.cmd_pop    (cmd_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_number (res_number),
		.res_valid  (res_valid),
		.res_end    (res_end)
	);

	dlp_fifo #(
		.WIDTH      (RES_W),
		.DEPTH_LOG2 (2)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data ({res_number, res_valid, res_end}),
		.rd_en   (pop),
		.rd_data (res_rd_data),
		.full    (res_full),
		.empty   (empty)
	);

	assign number       = res_rd_data[RES_W-1:2];
	assign number_valid = res_rd_data[1];
	assign list_end     = res_rd_data[0];

endmodule
